// ===== rtl/cta_pkg.sv =====
package cta_pkg;

  localparam int unsigned ChW     = 16;
  localparam int unsigned NumCh   = 3;
  localparam int unsigned RegIdxW = 3;

  typedef logic [ChW-1:0]   ch_t;
  typedef logic [2*ChW-1:0] wide_t;

  localparam ch_t Full = '1;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY_RED    = 3'd0,
    REG_KEY_GREEN  = 3'd1,
    REG_KEY_BLUE   = 3'd2,
    REG_CLEAR_LIM  = 3'd3,
    REG_OPAQUE_LIM = 3'd4,
    REG_COMPRESS   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_RAMP = 2'd2
  } cls_e;

  typedef struct packed {
    ch_t in_red;
    ch_t in_green;
    ch_t in_blue;
    ch_t in_alpha;
  } pix_in_t;

  typedef struct packed {
    ch_t out_red;
    ch_t out_green;
    ch_t out_blue;
    ch_t out_alpha;
  } pix_out_t;

  typedef struct packed {
    ch_t [NumCh-1:0] key;
    ch_t             clear_lim;
    ch_t             opaque_lim;
    logic            compress;
  } cfg_t;

  typedef struct packed {
    ch_t  [NumCh-1:0] src;
    ch_t              a_src;
    logic [NumCh-1:0] below;
    ch_t  [NumCh-1:0] d;
    cls_e [NumCh-1:0] cls;
    ch_t              tt;
  } pa_t;

  typedef struct packed {
    ch_t  [NumCh-1:0] src;
    ch_t              a_src;
    logic [NumCh-1:0] below;
    ch_t              alpha;
    logic             unmix;
  } pb_t;

  typedef struct packed {
    ch_t  [NumCh-1:0] src;
    ch_t  [NumCh-1:0] c;
    logic [NumCh-1:0] c_high;
    logic             unmix;
    wide_t            aprod;
  } pc_t;

  function automatic ch_t div_full_round(input wide_t p);
    logic [2*ChW:0] y;
    logic [ChW:0]   q0;
    logic [ChW:0]   r;
    logic [ChW:0]   q;
    y  = {1'b0, p} + (2*ChW+1)'(Full >> 1);
    q0 = y[2*ChW:ChW];
    r  = {1'b0, y[ChW-1:0]} + q0;
    q  = q0 + ((r >= {1'b0, Full}) ? (ChW+1)'(1) : (ChW+1)'(0));
    return q[ChW-1:0];
  endfunction

endpackage

// ===== rtl/cta_div.sv =====
module cta_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned QUO_W = 16,
  parameter int unsigned PAY_W = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic [cta_pkg::NumCh-1:0][NUM_W-1:0]       num_i,
  input  logic [cta_pkg::NumCh-1:0][DEN_W-1:0]       den_i,
  input  logic [PAY_W-1:0]                           pay_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic [cta_pkg::NumCh-1:0][QUO_W-1:0]       quo_o,
  output logic [cta_pkg::NumCh-1:0]                  ovf_o,
  output logic [PAY_W-1:0]                           pay_o
);
  import cta_pkg::*;

  localparam int unsigned NStg = QUO_W + 1;
  localparam int unsigned CmpW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg:0]   rdy;

  logic [NumCh-1:0][DEN_W-1:0] r_q   [NStg];
  logic [NumCh-1:0][DEN_W-1:0] den_q [NStg];
  logic [NumCh-1:0][QUO_W-1:0] sh_q  [NStg];
  logic [NumCh-1:0]            ovf_q [NStg];
  logic [PAY_W-1:0]            pay_q [NStg];

  assign rdy[NStg] = ready_i;
  assign vin       = {v_q[NStg-2:0], valid_i};

  for (genvar s = 0; s < NStg; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NStg; s++) begin
        if (rdy[s]) begin
          v_q[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int c = 0; c < NumCh; c++) begin
        r_q[0][c]   <= DEN_W'(num_i[c] >> QUO_W);
        sh_q[0][c]  <= num_i[c][QUO_W-1:0];
        den_q[0][c] <= den_i[c];
        ovf_q[0][c] <= CmpW'(num_i[c]) >= (CmpW'(den_i[c]) << QUO_W);
      end
      pay_q[0] <= pay_i;
    end
  end

  for (genvar s = 1; s < NStg; s++) begin : g_step
    logic [NumCh-1:0][DEN_W-1:0] r_d;
    logic [NumCh-1:0][QUO_W-1:0] sh_d;
    logic [NumCh-1:0][DEN_W:0]   t;
    logic [NumCh-1:0]            ge;

    always_comb begin
      for (int c = 0; c < NumCh; c++) begin
        t[c]    = {r_q[s-1][c], sh_q[s-1][c][QUO_W-1]};
        ge[c]   = t[c] >= {1'b0, den_q[s-1][c]};
        r_d[c]  = ge[c] ? DEN_W'(t[c] - {1'b0, den_q[s-1][c]}) : t[c][DEN_W-1:0];
        sh_d[c] = {sh_q[s-1][c][QUO_W-2:0], ge[c]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        r_q[s]   <= r_d;
        sh_q[s]  <= sh_d;
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        pay_q[s] <= pay_q[s-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign quo_o   = sh_q[NStg-1];
  assign ovf_o   = ovf_q[NStg-1];
  assign pay_o   = pay_q[NStg-1];

endmodule

// ===== rtl/cta_front.sv =====
module cta_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cta_pkg::cfg_t                          cfg_i,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  cta_pkg::pix_in_t                       pix_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output cta_pkg::wide_t [cta_pkg::NumCh-1:0]    num_o,
  output cta_pkg::ch_t   [cta_pkg::NumCh-1:0]    den_o,
  output cta_pkg::pa_t                           pay_o
);
  import cta_pkg::*;

  localparam int unsigned NStg = 5;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg:0]   rdy;

  assign rdy[NStg] = ready_i;
  assign vin       = {v_q[NStg-2:0], valid_i};

  for (genvar s = 0; s < NStg; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NStg; s++) begin
        if (rdy[s]) begin
          v_q[s] <= vin[s];
        end
      end
    end
  end

  pix_in_t pix1_q;
  ch_t [NumCh-1:0] src1;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pix1_q <= pix_i;
    end
  end

  assign src1 = {pix1_q.in_blue, pix1_q.in_green, pix1_q.in_red};

  ch_t  [NumCh-1:0] ext_e;
  ch_t              ext;
  logic [NumCh-1:0] below2_d;
  ch_t  [NumCh-1:0] d2_d;

  always_comb begin
    ext = '0;
    for (int i = 0; i < NumCh; i++) begin
      ext_e[i]    = (cfg_i.key[i] > Full - cfg_i.key[i]) ? cfg_i.key[i] : Full - cfg_i.key[i];
      below2_d[i] = src1[i] < cfg_i.key[i];
      d2_d[i]     = below2_d[i] ? cfg_i.key[i] - src1[i] : src1[i] - cfg_i.key[i];
    end
    for (int i = 0; i < NumCh; i++) begin
      if (ext_e[i] > ext) begin
        ext = ext_e[i];
      end
    end
  end

  ch_t  [NumCh-1:0] src2_q;
  ch_t              a2_q;
  logic [NumCh-1:0] below2_q;
  ch_t  [NumCh-1:0] d2_q;
  wide_t            ptt2_q;
  wide_t            pot2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      src2_q   <= src1;
      a2_q     <= pix1_q.in_alpha;
      below2_q <= below2_d;
      d2_q     <= d2_d;
      ptt2_q   <= wide_t'(cfg_i.clear_lim) * wide_t'(ext);
      pot2_q   <= wide_t'(cfg_i.opaque_lim) * wide_t'(ext);
    end
  end

  ch_t  [NumCh-1:0] src3_q;
  ch_t              a3_q;
  logic [NumCh-1:0] below3_q;
  ch_t  [NumCh-1:0] d3_q;
  ch_t              tt3_q;
  ch_t              ot3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      src3_q   <= src2_q;
      a3_q     <= a2_q;
      below3_q <= below2_q;
      d3_q     <= d2_q;
      tt3_q    <= cfg_i.compress ? div_full_round(ptt2_q) : cfg_i.clear_lim;
      ot3_q    <= cfg_i.compress ? div_full_round(pot2_q) : cfg_i.opaque_lim;
    end
  end

  pa_t             pa4_d;
  ch_t [NumCh-1:0] room;
  ch_t [NumCh-1:0] lim;
  ch_t [NumCh-1:0] den4_d;
  ch_t [NumCh-1:0] dt4_d;

  always_comb begin
    pa4_d.src   = src3_q;
    pa4_d.a_src = a3_q;
    pa4_d.below = below3_q;
    pa4_d.d     = d3_q;
    pa4_d.tt    = tt3_q;
    for (int i = 0; i < NumCh; i++) begin
      room[i]   = below3_q[i] ? cfg_i.key[i] : Full - cfg_i.key[i];
      lim[i]    = (ot3_q < room[i]) ? ot3_q : room[i];
      den4_d[i] = (lim[i] > tt3_q) ? lim[i] - tt3_q : ch_t'(1);
      dt4_d[i]  = d3_q[i] - tt3_q;
      if (d3_q[i] <= tt3_q) begin
        pa4_d.cls[i] = CLS_ZERO;
      end else if (d3_q[i] >= ot3_q) begin
        pa4_d.cls[i] = CLS_FULL;
      end else begin
        pa4_d.cls[i] = CLS_RAMP;
      end
    end
  end

  pa_t             pa4_q;
  ch_t [NumCh-1:0] den4_q;
  ch_t [NumCh-1:0] dt4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      pa4_q  <= pa4_d;
      den4_q <= den4_d;
      dt4_q  <= dt4_d;
    end
  end

  wide_t [NumCh-1:0] num5_d;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      num5_d[i] = {dt4_q[i], {ChW{1'b0}}} - wide_t'(dt4_q[i]) + wide_t'(den4_q[i] >> 1);
    end
  end

  pa_t               pa5_q;
  ch_t   [NumCh-1:0] den5_q;
  wide_t [NumCh-1:0] num5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      pa5_q  <= pa4_q;
      den5_q <= den4_q;
      num5_q <= num5_d;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign num_o   = num5_q;
  assign den_o   = den5_q;
  assign pay_o   = pa5_q;

endmodule

// ===== rtl/cta_mid.sv =====
module cta_mid (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  cta_pkg::ch_t   [cta_pkg::NumCh-1:0]    quo_i,
  input  logic           [cta_pkg::NumCh-1:0]    ovf_i,
  input  cta_pkg::pa_t                           pay_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output cta_pkg::wide_t [cta_pkg::NumCh-1:0]    num_o,
  output cta_pkg::ch_t   [cta_pkg::NumCh-1:0]    den_o,
  output cta_pkg::pb_t                           pay_o
);
  import cta_pkg::*;

  localparam int unsigned NStg = 2;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg:0]   rdy;

  assign rdy[NStg] = ready_i;
  assign vin       = {v_q[NStg-2:0], valid_i};

  for (genvar s = 0; s < NStg; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NStg; s++) begin
        if (rdy[s]) begin
          v_q[s] <= vin[s];
        end
      end
    end
  end

  ch_t [NumCh-1:0] a_c;
  ch_t             alpha;
  ch_t             win_dist;

  always_comb begin
    alpha    = '0;
    win_dist = '0;
    for (int i = 0; i < NumCh; i++) begin
      case (pay_i.cls[i])
        CLS_ZERO: a_c[i] = '0;
        CLS_FULL: a_c[i] = Full;
        CLS_RAMP: a_c[i] = ovf_i[i] ? Full : quo_i[i];
        default:  a_c[i] = '0;
      endcase
    end
    for (int i = 0; i < NumCh; i++) begin
      if (a_c[i] > alpha) begin
        alpha    = a_c[i];
        win_dist = pay_i.d[i];
      end
    end
  end

  pa_t  pa1_q;
  ch_t  alpha1_q;
  ch_t  dist1_q;
  logic unmix1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pa1_q    <= pay_i;
      alpha1_q <= alpha;
      dist1_q  <= win_dist;
      unmix1_q <= (alpha > ch_t'(1)) && (win_dist != '0);
    end
  end

  pb_t               pb2_q;
  wide_t [NumCh-1:0] num2_q;
  ch_t   [NumCh-1:0] den2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < NumCh; i++) begin
        num2_q[i] <= wide_t'(pa1_q.d[i]) * wide_t'(pa1_q.tt) + wide_t'(dist1_q >> 1);
        den2_q[i] <= dist1_q;
      end
      pb2_q.src   <= pa1_q.src;
      pb2_q.a_src <= pa1_q.a_src;
      pb2_q.below <= pa1_q.below;
      pb2_q.alpha <= alpha1_q;
      pb2_q.unmix <= unmix1_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign num_o   = num2_q;
  assign den_o   = den2_q;
  assign pay_o   = pb2_q;

endmodule

// ===== rtl/cta_back.sv =====
module cta_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cta_pkg::cfg_t                          cfg_i,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  cta_pkg::ch_t   [cta_pkg::NumCh-1:0]    quo_i,
  input  logic           [cta_pkg::NumCh-1:0]    ovf_i,
  input  cta_pkg::pb_t                           pay_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output cta_pkg::wide_t [cta_pkg::NumCh-1:0]    num_o,
  output cta_pkg::ch_t   [cta_pkg::NumCh-1:0]    den_o,
  output cta_pkg::pc_t                           pay_o
);
  import cta_pkg::*;

  localparam int unsigned NStg = 3;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg:0]   rdy;

  assign rdy[NStg] = ready_i;
  assign vin       = {v_q[NStg-2:0], valid_i};

  for (genvar s = 0; s < NStg; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NStg; s++) begin
        if (rdy[s]) begin
          v_q[s] <= vin[s];
        end
      end
    end
  end

  logic [NumCh-1:0][ChW:0] qx;
  logic [NumCh-1:0][ChW:0] c1_x;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      qx[i]   = {1'b0, (ovf_i[i] ? Full : quo_i[i])};
      c1_x[i] = pay_i.below[i] ? {1'b0, cfg_i.key[i]} - qx[i] : {1'b0, cfg_i.key[i]} + qx[i];
    end
  end

  pb_t             pb1_q;
  ch_t [NumCh-1:0] c1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pb1_q <= pay_i;
      for (int i = 0; i < NumCh; i++) begin
        c1_q[i] <= c1_x[i][ChW-1:0];
      end
    end
  end

  pb_t              pb2_q;
  ch_t  [NumCh-1:0] c2_q;
  logic [NumCh-1:0] high2_q;
  ch_t  [NumCh-1:0] diff2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pb2_q <= pb1_q;
      c2_q  <= c1_q;
      for (int i = 0; i < NumCh; i++) begin
        high2_q[i] <= pb1_q.src[i] < c1_q[i];
        diff2_q[i] <= (pb1_q.src[i] < c1_q[i]) ? c1_q[i] - pb1_q.src[i]
                                               : pb1_q.src[i] - c1_q[i];
      end
    end
  end

  pc_t               pc3_q;
  wide_t [NumCh-1:0] num3_q;
  ch_t   [NumCh-1:0] den3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < NumCh; i++) begin
        num3_q[i] <= {diff2_q[i], {ChW{1'b0}}} - wide_t'(diff2_q[i])
                     + wide_t'(pb2_q.alpha >> 1);
        den3_q[i] <= pb2_q.alpha;
      end
      pc3_q.src    <= pb2_q.src;
      pc3_q.c      <= c2_q;
      pc3_q.c_high <= high2_q;
      pc3_q.unmix  <= pb2_q.unmix;
      pc3_q.aprod  <= wide_t'(pb2_q.a_src) * wide_t'(pb2_q.alpha);
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign num_o   = num3_q;
  assign den_o   = den3_q;
  assign pay_o   = pc3_q;

endmodule

// ===== rtl/color_to_alpha_pixel.sv =====
// An accepted word runs front, div a, mid, div b, back, div c, output register.
// Throughput: one pixel per cycle when not stalled; the three restoring divider
// pipelines (ramp alpha, key and color un-mix) retire one quotient bit per stage.
// Stalls back up stage by stage; empty stages still take new words.
// Reset (async, active low) empties the pipeline and loads the register defaults.
module color_to_alpha_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cta_pkg::pix_in_t              in_pix_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cta_pkg::pix_out_t             out_pix_o,
  input  logic                          cfg_we_i,
  input  logic [cta_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  cta_pkg::ch_t                  cfg_data_i
);
  import cta_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key        <= {NumCh{Full}};
      cfg_q.clear_lim  <= '0;
      cfg_q.opaque_lim <= Full;
      cfg_q.compress   <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_KEY_RED:    cfg_q.key[0]     <= cfg_data_i;
        REG_KEY_GREEN:  cfg_q.key[1]     <= cfg_data_i;
        REG_KEY_BLUE:   cfg_q.key[2]     <= cfg_data_i;
        REG_CLEAR_LIM:  cfg_q.clear_lim  <= cfg_data_i;
        REG_OPAQUE_LIM: cfg_q.opaque_lim <= cfg_data_i;
        REG_COMPRESS:   cfg_q.compress   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic               f_valid, f_ready;
  wide_t [NumCh-1:0]  f_num;
  ch_t   [NumCh-1:0]  f_den;
  pa_t                f_pay;
  logic               a_valid, a_ready;
  ch_t   [NumCh-1:0]  a_quo;
  logic  [NumCh-1:0]  a_ovf;
  pa_t                a_pay;
  logic               m_valid, m_ready;
  wide_t [NumCh-1:0]  m_num;
  ch_t   [NumCh-1:0]  m_den;
  pb_t                m_pay;
  logic               b_valid, b_ready;
  ch_t   [NumCh-1:0]  b_quo;
  logic  [NumCh-1:0]  b_ovf;
  pb_t                b_pay;
  logic               k_valid, k_ready;
  wide_t [NumCh-1:0]  k_num;
  ch_t   [NumCh-1:0]  k_den;
  pc_t                k_pay;
  logic               c_valid, c_ready;
  logic  [NumCh-1:0][ChW:0] c_quo;
  logic  [NumCh-1:0]  c_ovf;
  pc_t                c_pay;
  logic               in_ready;

  cta_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(in_valid_i), .ready_o(in_ready), .pix_i(in_pix_i),
    .valid_o(f_valid), .ready_i(f_ready),
    .num_o(f_num), .den_o(f_den), .pay_o(f_pay)
  );

  cta_div #(.NUM_W(2*ChW), .DEN_W(ChW), .QUO_W(ChW), .PAY_W($bits(pa_t))) u_div_a (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .num_i(f_num), .den_i(f_den), .pay_i(f_pay),
    .valid_o(a_valid), .ready_i(a_ready), .quo_o(a_quo), .ovf_o(a_ovf), .pay_o(a_pay)
  );

  cta_mid u_mid (
    .clk_i, .rst_ni,
    .valid_i(a_valid), .ready_o(a_ready), .quo_i(a_quo), .ovf_i(a_ovf), .pay_i(a_pay),
    .valid_o(m_valid), .ready_i(m_ready), .num_o(m_num), .den_o(m_den), .pay_o(m_pay)
  );

  cta_div #(.NUM_W(2*ChW), .DEN_W(ChW), .QUO_W(ChW), .PAY_W($bits(pb_t))) u_div_b (
    .clk_i, .rst_ni,
    .valid_i(m_valid), .ready_o(m_ready), .num_i(m_num), .den_i(m_den), .pay_i(m_pay),
    .valid_o(b_valid), .ready_i(b_ready), .quo_o(b_quo), .ovf_o(b_ovf), .pay_o(b_pay)
  );

  cta_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(b_valid), .ready_o(b_ready), .quo_i(b_quo), .ovf_i(b_ovf), .pay_i(b_pay),
    .valid_o(k_valid), .ready_i(k_ready), .num_o(k_num), .den_o(k_den), .pay_o(k_pay)
  );

  cta_div #(.NUM_W(2*ChW), .DEN_W(ChW), .QUO_W(ChW+1), .PAY_W($bits(pc_t))) u_div_c (
    .clk_i, .rst_ni,
    .valid_i(k_valid), .ready_o(k_ready), .num_i(k_num), .den_i(k_den), .pay_i(k_pay),
    .valid_o(c_valid), .ready_i(c_ready), .quo_o(c_quo), .ovf_o(c_ovf), .pay_o(c_pay)
  );

  logic [NumCh-1:0][ChW:0]   cx;
  logic [NumCh-1:0][ChW+1:0] sum;
  ch_t  [NumCh-1:0]          val;
  ch_t  [NumCh-1:0]          res;
  pix_out_t                  out_d;
  pix_out_t                  out_q;
  logic                      out_v_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      cx[i]  = {1'b0, c_pay.c[i]};
      sum[i] = {1'b0, cx[i]} + {1'b0, c_quo[i]};
      if (c_pay.c_high[i]) begin
        val[i] = (c_ovf[i] || (c_quo[i] > cx[i])) ? '0 : ch_t'(cx[i] - c_quo[i]);
      end else begin
        val[i] = (c_ovf[i] || (sum[i] > (ChW+2)'(Full))) ? Full : sum[i][ChW-1:0];
      end
      res[i] = c_pay.unmix ? val[i] : c_pay.src[i];
    end
    out_d.out_red   = res[0];
    out_d.out_green = res[1];
    out_d.out_blue  = res[2];
    out_d.out_alpha = div_full_round(c_pay.aprod);
  end

  assign c_ready = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (c_ready) begin
      out_v_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_v_q;
  assign out_pix_o   = out_q;

endmodule

// ===== rtl/cta_checker.sv =====
module cta_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input cta_pkg::pix_in_t              in_pix_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input cta_pkg::pix_out_t             out_pix_o,
  input logic                          cfg_we_i,
  input logic [cta_pkg::RegIdxW-1:0]   cfg_idx_i,
  input cta_pkg::ch_t                  cfg_data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_pix_o)))
    else $error("stalled output word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side drains");

  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind color_to_alpha_pixel cta_props u_cta_props (.*);

// ===== sim/cta_checker.sv =====
module cta_checker
  import cta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  pix_in_t  in_pix_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  pix_out_t out_pix_i,
  input  logic     cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  ch_t      cfg_data_i,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FullL = 65535;

  longint key_q [3];
  longint clear_q, opaque_q;
  bit     compress_q;
  pix_out_t expected_pix_q [$];

  function automatic longint rdiv(longint num, longint den);
    longint mag;
    longint q;
    if (den == 0) return 0;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint sat(longint v);
    return v < 0 ? 0 : (v > FullL ? FullL : v);
  endfunction

  function automatic pix_out_t unmix_pixel(pix_in_t p);
    longint src [3];
    longint res [3];
    longint tt, ot, ext, e, d, a, room, lim, den, alpha, win_dist, c, v;
    bit below;
    pix_out_t o;
    src[0] = p.in_red;
    src[1] = p.in_green;
    src[2] = p.in_blue;
    tt = clear_q;
    ot = opaque_q;
    alpha = 0;
    win_dist = 0;
    if (compress_q) begin
      ext = 0;
      for (int i = 0; i < 3; i++) begin
        e = key_q[i] > FullL - key_q[i] ? key_q[i] : FullL - key_q[i];
        if (e > ext) ext = e;
      end
      tt = rdiv(tt * ext, FullL);
      ot = rdiv(ot * ext, FullL);
    end
    for (int i = 0; i < 3; i++) begin
      below = src[i] < key_q[i];
      d = below ? key_q[i] - src[i] : src[i] - key_q[i];
      if (d <= tt) begin
        a = 0;
      end else if (d + 1 > ot) begin
        a = FullL;
      end else begin
        room = below ? key_q[i] : FullL - key_q[i];
        lim = ot < room ? ot : room;
        den = lim > tt ? lim - tt : 1;
        a = sat(rdiv((d - tt) * FullL, den));
      end
      if (a > alpha) begin
        alpha = a;
        win_dist = d;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i] = src[i];
      if (alpha > 1 && win_dist > 0) begin
        c = key_q[i] + rdiv((src[i] - key_q[i]) * tt, win_dist);
        v = c + rdiv((src[i] - c) * FullL, alpha);
        res[i] = sat(v);
      end
    end
    o.out_red   = ch_t'(res[0]);
    o.out_green = ch_t'(res[1]);
    o.out_blue  = ch_t'(res[2]);
    o.out_alpha = ch_t'(sat(rdiv(longint'(p.in_alpha) * alpha, FullL)));
    return o;
  endfunction

  task automatic compare_field(string name, ch_t exp_v, ch_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_pix_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pix_out_t exp_pix;
    if (!rst_ni) begin
      key_q = '{FullL, FullL, FullL};
      clear_q = 0;
      opaque_q = FullL;
      compress_q = 0;
      fail_count_o = 0;
      expected_pix_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pix_q.size() == 0) begin
          $error("unexpected output word %h", out_pix_i);
          fail_count_o++;
        end else begin
          exp_pix = expected_pix_q.pop_front();
          compare_field("out_red", exp_pix.out_red, out_pix_i.out_red);
          compare_field("out_green", exp_pix.out_green, out_pix_i.out_green);
          compare_field("out_blue", exp_pix.out_blue, out_pix_i.out_blue);
          compare_field("out_alpha", exp_pix.out_alpha, out_pix_i.out_alpha);
        end
      end
      if (in_valid_i && !in_stall_i) expected_pix_q.push_back(unmix_pixel(in_pix_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_RED:    key_q[0] = cfg_data_i;
          REG_KEY_GREEN:  key_q[1] = cfg_data_i;
          REG_KEY_BLUE:   key_q[2] = cfg_data_i;
          REG_CLEAR_LIM:  clear_q = cfg_data_i;
          REG_OPAQUE_LIM: opaque_q = cfg_data_i;
          REG_COMPRESS:   compress_q = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
module testbench;
  import cta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  pix_in_t  in_pix = '0;
  pix_out_t out_pix;
  logic cfg_we = 0;
  logic [RegIdxW-1:0] cfg_idx = '0;
  ch_t cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit stim_done = 0;

  always #5 clk_i = ~clk_i;

  color_to_alpha_pixel dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_pix_i(in_pix),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_pix_o(out_pix),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  cta_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_pix_i(in_pix),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_pix_i(out_pix),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic ch_t rand_ch();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ch_t'($urandom_range(0, 3));
      3: return ch_t'(16'hffff - $urandom_range(0, 3));
      default: return ch_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, ch_t val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic send_pixel(pix_in_t p);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1;
    in_pix <= p;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic set_config(ch_t kr, ch_t kg, ch_t kb, ch_t cl, ch_t op, bit cmp);
    write_reg(REG_KEY_RED, kr);
    write_reg(REG_KEY_GREEN, kg);
    write_reg(REG_KEY_BLUE, kb);
    write_reg(REG_CLEAR_LIM, cl);
    write_reg(REG_OPAQUE_LIM, op);
    write_reg(REG_COMPRESS, ch_t'(cmp));
    cfg_we <= 0;
  endtask

  initial begin
    pix_in_t p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: reset config, then extremes
    send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'hffff});
    send_pixel('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_pixel('{16'hfffe, 16'hffff, 16'hffff, 16'h8000});
    send_pixel('{16'h1234, 16'h8000, 16'hffff, 16'h0000});
    in_valid <= 0;
    drain();
    set_config(16'h8000, 16'h4000, 16'hc000, 16'h1000, 16'h6000, 1'b0);
    send_pixel('{16'h8000, 16'h4000, 16'hc000, 16'hffff});
    send_pixel('{16'h8001, 16'h4000, 16'hc000, 16'hffff});
    send_pixel('{16'h0000, 16'hffff, 16'h0000, 16'h7fff});
    send_pixel('{16'h8800, 16'h4400, 16'hc400, 16'hffff});
    send_pixel('{16'h9800, 16'h4000, 16'hc000, 16'h1234});
    in_valid <= 0;
    drain();
    // clear limit above opaque limit
    set_config(16'h0000, 16'hffff, 16'h8000, 16'h9000, 16'h1000, 1'b1);
    send_pixel('{16'h0000, 16'hffff, 16'h8000, 16'hffff});
    send_pixel('{16'hffff, 16'h0000, 16'h0000, 16'hffff});
    send_pixel('{16'h0800, 16'hf800, 16'h8800, 16'haaaa});
    in_valid <= 0;
    drain();
    set_config(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 1'b1);
    send_pixel('{16'h0001, 16'h0000, 16'h0000, 16'hffff});
    send_pixel('{16'hffff, 16'h5555, 16'h0000, 16'hffff});
    in_valid <= 0;
    drain();
    for (int ph = 0; ph < 11; ph++) begin
      set_config(rand_ch(), rand_ch(), rand_ch(), rand_ch(), rand_ch(),
                 1'($urandom_range(0, 1)));
      for (int n = 0; n < 50; n++) begin
        p = {rand_ch(), rand_ch(), rand_ch(), rand_ch()};
        send_pixel(p);
      end
      in_valid <= 0;
      drain();
    end
    stim_done = 1;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < 70) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 9) < 9) ? 1'b1 : 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else if (stim_done) begin
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
    end
  end
endmodule
